@@ rtl/spm_pkg.sv @@
// Package for the single-precision multiplier.
// Holds field widths, constants and types used across the modules.
package spm_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned SigW  = 24;
  localparam int unsigned ProdW = 48;
  localparam logic [ExpW-1:0] ExpMax = 8'hFF;
  localparam logic [9:0] Bias = 10'd127;

  typedef struct packed {
    logic             sign;
    logic [ExpW-1:0]  exp;
    logic [FracW-1:0] frac;
  } fp_t;

  typedef struct packed {
    logic       special;
    logic [WordW-1:0] special_word;
    logic       sign;
    logic [9:0] exp_sum;
  } spm_ctrl_t;
endpackage

@@ rtl/spm_mul_stage.sv @@
// First stage: special-case decode, exponent sum and significand product.
// Depends on spm_pkg.
module spm_mul_stage (
  input  logic [spm_pkg::WordW-1:0] a_i,
  input  logic [spm_pkg::WordW-1:0] b_i,
  output spm_pkg::spm_ctrl_t         ctrl_o,
  output logic [spm_pkg::ProdW-1:0] prod_o
);
  import spm_pkg::*;

  fp_t fa, fb;
  logic nan_a, nan_b, inf_a, inf_b, sgn;
  logic [SigW-1:0] ma, mb;

  always_comb begin
    fa = a_i;
    fb = b_i;
    nan_a = (fa.exp == ExpMax) && (fa.frac != '0);
    nan_b = (fb.exp == ExpMax) && (fb.frac != '0);
    inf_a = (fa.exp == ExpMax) && (fa.frac == '0);
    inf_b = (fb.exp == ExpMax) && (fb.frac == '0);
    sgn = fa.sign ^ fb.sign;
    ma = {(fa.exp != '0), fa.frac};
    mb = {(fb.exp != '0), fb.frac};
    prod_o = ma * mb;
    ctrl_o.sign = sgn;
    ctrl_o.exp_sum = {2'b00, fa.exp} + {2'b00, fb.exp} - Bias;
    ctrl_o.special = 1'b1;
    ctrl_o.special_word = '0;
    if (a_i == '0 || b_i == '0) begin
      ctrl_o.special_word = '0;
    end else if (nan_a) begin
      ctrl_o.special_word = a_i;
    end else if (nan_b) begin
      ctrl_o.special_word = b_i;
    end else if (inf_a || inf_b) begin
      ctrl_o.special_word = {sgn, ExpMax, {FracW{1'b0}}};
    end else begin
      ctrl_o.special = 1'b0;
    end
  end
endmodule

@@ rtl/spm_round_stage.sv @@
// Second stage: normalization, half-up rounding and range checks.
// Depends on spm_pkg.
module spm_round_stage (
  input  spm_pkg::spm_ctrl_t         ctrl_i,
  input  logic [spm_pkg::ProdW-1:0] prod_i,
  output logic [spm_pkg::WordW-1:0] word_o
);
  import spm_pkg::*;

  logic [ProdW-1:0] p;
  logic [9:0] e;
  logic [ProdW-23-1:0] kept;

  always_comb begin
    p = prod_i;
    e = ctrl_i.exp_sum;
    if (p[ProdW-1]) begin
      p = p >> 1;
      e = e + 10'd1;
    end
    kept = p[ProdW-1:23] + {{(ProdW-24){1'b0}}, p[22]};
    if (kept[SigW]) begin
      kept = kept >> 1;
      e = e + 10'd1;
    end
    if (ctrl_i.special) begin
      word_o = ctrl_i.special_word;
    end else if (prod_i == '0 || e[9] || e == '0) begin
      word_o = {ctrl_i.sign, {(WordW-1){1'b0}}};
    end else if (e >= 10'd255) begin
      word_o = {ctrl_i.sign, ExpMax, {FracW{1'b0}}};
    end else begin
      word_o = {ctrl_i.sign, e[ExpW-1:0], kept[FracW-1:0]};
    end
  end
endmodule

@@ rtl/single_precision_multiplier.sv @@
// Single-precision multiplier top level: input register, product register, result register.
// Requests move through these registers in order; one request per cycle unless stalled.
// The pipeline advances whenever the result register is empty or being taken.
// Reset clears all valid bits; payload registers are not reset.
// Depends on spm_pkg, spm_mul_stage and spm_round_stage.
module single_precision_multiplier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [spm_pkg::WordW-1:0]   operand_a_i,
  input  logic [spm_pkg::WordW-1:0]   operand_b_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [spm_pkg::WordW-1:0]   product_o
);
  import spm_pkg::*;

  logic adv;
  logic v1_q, v2_q, v3_q;
  logic [WordW-1:0] a_q, b_q, res_q, word_d;
  spm_ctrl_t ctrl_d, ctrl_q;
  logic [ProdW-1:0] prod_d, prod_q;

  assign adv = !v3_q || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = v3_q;
  assign product_o = res_q;

  spm_mul_stage u_mul (.a_i(a_q), .b_i(b_q), .ctrl_o(ctrl_d), .prod_o(prod_d));
  spm_round_stage u_rnd (.ctrl_i(ctrl_q), .prod_i(prod_q), .word_o(word_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q <= operand_a_i;
      b_q <= operand_b_i;
      ctrl_q <= ctrl_d;
      prod_q <= prod_d;
      res_q <= word_d;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(product_o))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && v2_q |=> out_valid_o)
    else $error("pipeline dropped a request");
endmodule
